[src/cowm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the clock offset window monitor.
// No dependencies.
package cowm_pkg;

  localparam int OP_W    = 3;
  localparam int TIME_W  = 48;
  localparam int OFS_W   = 32;
  localparam int CONF_W  = 17;
  localparam int ISSUE_W = 2;
  localparam int NUM_WIN = 3;
  localparam int DIV_NW  = 48;
  localparam int DIV_DW  = 32;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 32;
  localparam int WLEN_W  = 7;
  localparam int IN_DW   = 96;
  localparam int OUT_DW  = 152;
  localparam logic [DIV_DW-1:0] MIN_DEGRADED = 32'd1000;

  typedef enum logic [OP_W-1:0] {
    OP_IMU    = 3'd0,
    OP_CAMERA = 3'd1,
    OP_ANCHOR = 3'd2,
    OP_PEER   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    WIN_IC = 2'd0,
    WIN_AN = 2'd1,
    WIN_PE = 2'd2
  } win_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_DEGRADED      = 2'd1,
    REG_SYNC          = 2'd2
  } reg_idx_t;

  typedef enum logic [ISSUE_W-1:0] {
    ISSUE_STABLE = 2'd0,
    ISSUE_ANCHOR = 2'd1,
    ISSUE_PEER   = 2'd2,
    ISSUE_IC     = 2'd3
  } issue_t;

  typedef enum logic [1:0] {
    DIV_SUM  = 2'd0,
    DIV_DEV  = 2'd1,
    DIV_CONF = 2'd2
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_WIN_INIT,
    ST_SUM_RUN,
    ST_SUM_DIV,
    ST_DEV_RUN,
    ST_DEV_DIV,
    ST_WIN_NEXT,
    ST_CONF_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     push;
    logic     win_first;
    logic     win_adv;
    logic     scan_start;
    logic     scan_pass;
    logic     div_start;
    div_sel_t div_sel;
    logic     mean_take;
    logic     mad_take;
    logic     out_load;
  } cowm_cmd_t;

  typedef struct packed {
    logic win_empty;
    logic win_last;
    logic scan_busy;
    logic div_busy;
  } cowm_stat_t;

endpackage

[src/cowm_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module cowm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/cowm_div.sv]
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on cowm_pkg.
module cowm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cowm_pkg::DIV_NW-1:0] num,
  input  logic [cowm_pkg::DIV_DW-1:0] den,
  output logic                        busy,
  output logic [cowm_pkg::DIV_NW-1:0] quo
);
  import cowm_pkg::*;

  localparam int CNT_W = $clog2(DIV_NW);

  logic [DIV_NW-1:0] q_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic [DIV_DW:0]   rem_sh;
  logic              bit_q;
  logic [DIV_DW:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem_r, q_r[DIV_NW-1]};
    bit_q   = (rem_sh >= {1'b0, den_r});
    rem_sub = bit_q ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_NW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[DIV_NW-2:0], bit_q};
      rem_r <= rem_sub[DIV_DW-1:0];
    end
  end

  assign busy = busy_r;
  assign quo  = q_r;

endmodule

[src/cowm_datapath.sv]
`timescale 1ns / 1ps
// Datapath: config registers, offset windows, scan accumulators, divider, result register.
// Depends on cowm_pkg, cowm_ram, cowm_div.
module cowm_datapath #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cowm_pkg::cowm_cmd_t          cmd,
  output cowm_pkg::cowm_stat_t         stat,
  input  logic                         cfg_we,
  input  logic [cowm_pkg::CFG_IW-1:0]  cfg_idx,
  input  logic [cowm_pkg::CFG_DW-1:0]  cfg_data,
  input  logic [cowm_pkg::OP_W-1:0]    in_op,
  input  logic [cowm_pkg::IN_DW-1:0]   in_data,
  output logic [cowm_pkg::OUT_DW-1:0]  out_data
);
  import cowm_pkg::*;

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = 33 + CW;

  // configuration
  logic [WLEN_W-1:0] wlen_r;
  logic [DIV_DW-1:0] deg_r;
  logic [DIV_DW-1:0] sync_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WLEN_W'(64);
      deg_r  <= 32'd50000;
      sync_r <= 32'd5000;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WINDOW_LENGTH: wlen_r <= cfg_data[WLEN_W-1:0];
        REG_DEGRADED:      deg_r  <= cfg_data;
        REG_SYNC:          sync_r <= cfg_data;
        default:           ;
      endcase
    end
  end

  // captured item
  logic [OP_W-1:0]   op_r;
  logic [TIME_W-1:0] ta_r;
  logic [TIME_W-1:0] tb_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_op;
      ta_r <= in_data[TIME_W-1:0];
      tb_r <= in_data[2*TIME_W-1:TIME_W];
    end
  end

  // offset generation
  logic signed [TIME_W:0] last_imu_r;
  logic signed [TIME_W:0] last_cam_r;
  logic signed [TIME_W+1:0] diff;
  logic [OFS_W-1:0] ofs;
  logic             do_push;
  logic [1:0]       pw;
  logic [CW-1:0]    len;

  always_comb begin
    diff    = '0;
    do_push = 1'b0;
    pw      = WIN_IC;
    case (op_r)
      OP_IMU: begin
        diff    = {last_cam_r[TIME_W], last_cam_r} - {2'b00, ta_r};
        do_push = !last_cam_r[TIME_W] && (|last_cam_r);
      end
      OP_CAMERA: begin
        diff    = {2'b00, ta_r} - {last_imu_r[TIME_W], last_imu_r};
        do_push = !last_imu_r[TIME_W] && (|last_imu_r);
      end
      OP_ANCHOR: begin
        diff    = {2'b00, ta_r} - {2'b00, tb_r};
        do_push = 1'b1;
        pw      = WIN_AN;
      end
      OP_PEER: begin
        diff    = {2'b00, ta_r} - {2'b00, tb_r};
        do_push = 1'b1;
        pw      = WIN_PE;
      end
      default: ;
    endcase
    if (!diff[TIME_W+1] && (|diff[TIME_W:OFS_W-1])) begin
      ofs = {1'b0, {(OFS_W-1){1'b1}}};
    end else if (diff[TIME_W+1] && !(&diff[TIME_W:OFS_W-1])) begin
      ofs = {1'b1, {(OFS_W-1){1'b0}}};
    end else begin
      ofs = diff[OFS_W-1:0];
    end
    if ({25'd0, wlen_r} > 32'(WINDOW_DEPTH)) begin
      len = CW'(WINDOW_DEPTH);
    end else begin
      len = CW'(wlen_r);
    end
  end

  // window bookkeeping
  logic [AW-1:0] head_r [NUM_WIN];
  logic [CW-1:0] fill_r [NUM_WIN];
  logic [CW-1:0] fill_inc;

  always_comb begin
    fill_inc = (fill_r[pw] < CW'(WINDOW_DEPTH)) ? fill_r[pw] + 1'b1 : fill_r[pw];
    if (fill_inc > len) begin
      fill_inc = len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_imu_r <= '1;
      last_cam_r <= '1;
      for (int i = 0; i < NUM_WIN; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else if (cmd.push) begin
      if (op_r == OP_CLEAR) begin
        last_imu_r <= '1;
        last_cam_r <= '1;
        for (int i = 0; i < NUM_WIN; i++) begin
          head_r[i] <= '0;
          fill_r[i] <= '0;
        end
      end else begin
        if (op_r == OP_IMU) begin
          last_imu_r <= {1'b0, ta_r};
        end
        if (op_r == OP_CAMERA) begin
          last_cam_r <= {1'b0, ta_r};
        end
        if (do_push) begin
          head_r[pw] <= (head_r[pw] == AW'(WINDOW_DEPTH - 1)) ? '0 : head_r[pw] + 1'b1;
          fill_r[pw] <= fill_inc;
        end
      end
    end
  end

  // window storage
  logic [1:0]       win_r;
  logic [AW-1:0]    raddr_r;
  logic [OFS_W-1:0] rd [NUM_WIN];

  for (genvar g = 0; g < NUM_WIN; g++) begin : g_win
    cowm_ram #(
      .WIDTH (OFS_W),
      .DEPTH (WINDOW_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (cmd.push && do_push && (op_r != OP_CLEAR) && (pw == 2'(g))),
      .waddr (head_r[g]),
      .wdata (ofs),
      .raddr (raddr_r),
      .rdata (rd[g])
    );
  end

  // scan over the selected window
  logic [CW-1:0] n;
  logic [CW:0]   st_w;
  logic [AW-1:0] st;
  logic [CW-1:0] cnt_r;
  logic          act_r;
  logic          dvld_r;
  logic          pass_r;
  logic signed [SW-1:0] sum_r;
  logic [SW-1:0]        dev_r;
  logic signed [OFS_W-1:0] mean_r [NUM_WIN];
  logic [OFS_W-1:0]        mad_r  [NUM_WIN];
  logic signed [OFS_W-1:0] x;
  logic signed [OFS_W:0]   dx;
  logic [OFS_W:0]          adx;

  always_comb begin
    n    = fill_r[win_r];
    st_w = {1'b0, CW'(head_r[win_r])} + (CW + 1)'(WINDOW_DEPTH) - {1'b0, n};
    if (st_w >= (CW + 1)'(WINDOW_DEPTH)) begin
      st_w = st_w - (CW + 1)'(WINDOW_DEPTH);
    end
    st  = st_w[AW-1:0];
    x   = rd[win_r];
    dx  = {x[OFS_W-1], x} - {mean_r[win_r][OFS_W-1], mean_r[win_r]};
    adx = dx[OFS_W] ? -dx : dx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      dvld_r <= 1'b0;
      win_r  <= WIN_IC;
    end else begin
      dvld_r <= act_r;
      if (cmd.win_first) begin
        win_r <= WIN_IC;
      end else if (cmd.win_adv) begin
        win_r <= win_r + 1'b1;
      end
      if (cmd.scan_start) begin
        act_r <= 1'b1;
      end else if (act_r && (cnt_r == n - 1'b1)) begin
        act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      raddr_r <= st;
      cnt_r   <= '0;
      pass_r  <= cmd.scan_pass;
      sum_r   <= '0;
      dev_r   <= '0;
    end else begin
      if (act_r) begin
        raddr_r <= (raddr_r == AW'(WINDOW_DEPTH - 1)) ? '0 : raddr_r + 1'b1;
        cnt_r   <= cnt_r + 1'b1;
      end
      if (dvld_r) begin
        if (pass_r) begin
          dev_r <= dev_r + {{(SW-OFS_W-1){1'b0}}, adx};
        end else begin
          sum_r <= sum_r + {{(SW-OFS_W){x[OFS_W-1]}}, x};
        end
      end
    end
  end

  // divider and status math
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_NW-1:0] quo;
  logic              div_busy;
  logic [SW-1:0]     sum_mag;
  logic [DIV_DW-1:0] dthr;
  logic [OFS_W-1:0]  am [NUM_WIN];
  logic [OFS_W-1:0]  worst;
  logic [OFS_W-1:0]  jitter;
  logic              sync;
  logic [ISSUE_W-1:0] issue;
  logic [CONF_W-1:0] conf;
  logic [OFS_W-1:0]  q32;

  always_comb begin
    sum_mag = sum_r[SW-1] ? -sum_r : sum_r;
    dthr    = (deg_r < MIN_DEGRADED) ? MIN_DEGRADED : deg_r;
    for (int i = 0; i < NUM_WIN; i++) begin
      am[i] = mean_r[i][OFS_W-1] ? -mean_r[i] : mean_r[i];
    end
    worst = am[WIN_IC];
    if (am[WIN_AN] > worst) worst = am[WIN_AN];
    if (am[WIN_PE] > worst) worst = am[WIN_PE];
    jitter = mad_r[WIN_IC];
    if (mad_r[WIN_AN] > jitter) jitter = mad_r[WIN_AN];
    if (mad_r[WIN_PE] > jitter) jitter = mad_r[WIN_PE];
    sync = (worst <= sync_r) && (jitter <= sync_r);
    if (sync) begin
      issue = ISSUE_STABLE;
    end else if ((am[WIN_AN] >= am[WIN_IC]) && (am[WIN_AN] >= am[WIN_PE])) begin
      issue = ISSUE_ANCHOR;
    end else if (am[WIN_PE] >= am[WIN_IC]) begin
      issue = ISSUE_PEER;
    end else begin
      issue = ISSUE_IC;
    end
    conf = (worst >= dthr) ? '0 : quo[CONF_W-1:0];
    q32  = quo[OFS_W-1:0];
    case (cmd.div_sel)
      DIV_SUM: begin
        div_num = {{(DIV_NW-SW){1'b0}}, sum_mag};
        div_den = DIV_DW'(n);
      end
      DIV_DEV: begin
        div_num = {{(DIV_NW-SW){1'b0}}, dev_r};
        div_den = DIV_DW'(n);
      end
      default: begin
        div_num = (worst >= dthr) ? '0 : {dthr - worst, 16'd0};
        div_den = dthr;
      end
    endcase
  end

  cowm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.mean_take) begin
      mean_r[win_r] <= (n == '0) ? '0 : (sum_r[SW-1] ? -q32 : q32);
    end
    if (cmd.mad_take) begin
      mad_r[win_r] <= (n == '0) ? '0 : q32;
    end
    if (cmd.out_load) begin
      out_data <= {4'd0, issue, sync, conf, jitter,
                   mean_r[WIN_PE], mean_r[WIN_AN], mean_r[WIN_IC]};
    end
  end

  assign stat.win_empty = (n == '0);
  assign stat.win_last  = (win_r == WIN_PE);
  assign stat.scan_busy = act_r || dvld_r;
  assign stat.div_busy  = div_busy;

endmodule

[src/cowm_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences push, per-window scans and divisions, and the result handshake.
// Depends on cowm_pkg.
module cowm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  cowm_pkg::cowm_stat_t stat,
  output cowm_pkg::cowm_cmd_t  cmd
);
  import cowm_pkg::*;

  state_t state_r, state_nxt;
  logic   ovld_r, ovld_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = DIV_SUM;
    ovld_nxt  = ovld_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push      = 1'b1;
        cmd.win_first = 1'b1;
        state_nxt     = ST_WIN_INIT;
      end
      ST_WIN_INIT: begin
        if (stat.win_empty) begin
          cmd.mean_take = 1'b1;
          cmd.mad_take  = 1'b1;
          state_nxt     = ST_WIN_NEXT;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SUM_RUN;
        end
      end
      ST_SUM_RUN: begin
        cmd.div_sel = DIV_SUM;
        if (!stat.scan_busy) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_SUM_DIV;
        end
      end
      ST_SUM_DIV: begin
        if (!stat.div_busy) begin
          cmd.mean_take  = 1'b1;
          cmd.scan_start = 1'b1;
          cmd.scan_pass  = 1'b1;
          state_nxt      = ST_DEV_RUN;
        end
      end
      ST_DEV_RUN: begin
        cmd.div_sel = DIV_DEV;
        if (!stat.scan_busy) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DEV_DIV;
        end
      end
      ST_DEV_DIV: begin
        if (!stat.div_busy) begin
          cmd.mad_take = 1'b1;
          state_nxt    = ST_WIN_NEXT;
        end
      end
      ST_WIN_NEXT: begin
        if (stat.win_last) begin
          cmd.div_sel   = DIV_CONF;
          cmd.div_start = 1'b1;
          state_nxt     = ST_CONF_DIV;
        end else begin
          cmd.win_adv = 1'b1;
          state_nxt   = ST_WIN_INIT;
        end
      end
      ST_CONF_DIV: begin
        cmd.div_sel = DIV_CONF;
        if (!stat.div_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.div_sel = DIV_CONF;
        if (!ovld_r || out_tready) begin
          cmd.out_load = 1'b1;
          ovld_nxt     = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovld_r;

endmodule

[src/clock_offset_window_monitor.sv]
`timescale 1ns / 1ps
// Top level of the clock offset window monitor: controller plus datapath.
// Depends on cowm_pkg, cowm_ctrl, cowm_datapath.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_tvalid/tready   | tuser opcode, tdata time_a/time_b
//  out_    | output    | out_tvalid/tready  | tdata means, jitter, confidence, flags
//  cfg_    | input     | cfg_valid/ready    | cfg_index, cfg_data
//
// From acceptance to the result load, each non-empty window takes two scans through its
// single read port and two bit-serial divisions, and the confidence one more division.
// Reset is synchronous and clears control state at once. A result waiting at the output
// does not stop the next event; only the final load waits on out_tready.
module clock_offset_window_monitor #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [cowm_pkg::IN_DW-1:0]    in_tdata,  // time_a_us[47:0], time_b_us[95:48]
  input  logic [cowm_pkg::OP_W-1:0]     in_tuser,  // opcode[2:0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // imu_camera_offset_us[31:0], anchor_offset_us[63:32], peer_offset_us[95:64],
  // jitter_us[127:96], confidence_q16[144:128], synchronized[145], issue_code[147:146]
  output logic [cowm_pkg::OUT_DW-1:0]   out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cowm_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [cowm_pkg::CFG_DW-1:0]   cfg_data
);
  import cowm_pkg::*;

  cowm_cmd_t  cmd;
  cowm_stat_t stat;

  assign cfg_ready = 1'b1;

  cowm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  cowm_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_idx  (cfg_index),
    .cfg_data (cfg_data),
    .in_op    (in_tuser),
    .in_data  (in_tdata),
    .out_data (out_tdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[144:128] <= 17'd65536)
    else $error("confidence above one");

  a_sync_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[145] |-> out_tdata[147:146] == ISSUE_STABLE)
    else $error("synchronized result with an issue code");

  a_divider_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !stat.div_busy && !stat.scan_busy)
    else $error("item accepted while datapath busy");

endmodule
